FILE: sv/ghalloc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ghalloc_pkg
// Shared types and constants of the generational handle allocator: operation
// and status codes, field widths, the controller state type and the result
// record handed from the controller to the output stage.
// ----------------------------------------------------------------------------
package ghalloc_pkg;

    // Field widths of the stream payloads.
    localparam int MODE_W    = 3;
    localparam int HIDX_W    = 8;
    localparam int GEN_W     = 32;
    localparam int EPOCH_W   = 32;
    localparam int STATUS_W  = 3;
    localparam int LIVE_W    = 9;

    localparam int IN_TDATA_W  = 72;
    localparam int IN_TUSER_W  = 3;
    localparam int OUT_TDATA_W = 88;
    localparam int OUT_TUSER_W = 3;

    localparam logic [GEN_W-1:0]   GEN_MAX   = '1;
    localparam logic [EPOCH_W-1:0] EPOCH_MAX = '1;
    localparam logic [GEN_W-1:0]   GEN_FIRST = GEN_W'(1);

    // Operation codes carried in the input tuser.
    localparam logic [MODE_W-1:0] MODE_ALLOC   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_RELEASE = 3'd1;
    localparam logic [MODE_W-1:0] MODE_CHECK   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_CLEAR   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_QUERY   = 3'd4;

    // Status codes carried in the output tuser.
    localparam logic [STATUS_W-1:0] STATUS_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_STALE     = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_EXHAUSTED = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_NOT_LIVE  = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_POP,
        ST_SWEEP
    } state_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [HIDX_W-1:0]   index;
        logic [GEN_W-1:0]    generation;
        logic [EPOCH_W-1:0]  epoch;
        logic                is_live;
        logic [LIVE_W-1:0]   live_total;
    } result_t;

endpackage

FILE: sv/ghalloc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ghalloc_ram
// Generic simple dual-port RAM: one write port, one read port with the read
// data registered. Read data holds while rd_en is low.
// ----------------------------------------------------------------------------
module ghalloc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: sv/ghalloc_outreg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ghalloc_outreg
// Output register stage: holds one result record and presents it on the
// master stream until the receiver takes it.
// ----------------------------------------------------------------------------
module ghalloc_outreg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                res_valid,
    input  ghalloc_pkg::result_t                res,
    output logic                                res_ready,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // index[7:0], generation[39:8], epoch[71:40], is_live[72],
    // live_total[81:73], zero fill[87:82]
    output logic [ghalloc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // status[2:0]
    output logic [ghalloc_pkg::OUT_TUSER_W-1:0] m_axis_tuser
);

    logic                 valid_reg;
    logic                 valid_next;
    ghalloc_pkg::result_t data_reg;

    // The stage can take a new record when empty or when its record leaves now.
    assign res_ready = !valid_reg || m_axis_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (res_valid)
        begin
            valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            data_reg <= res;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tuser  = data_reg.status;
    assign m_axis_tdata  = {6'd0, data_reg.live_total, data_reg.is_live, data_reg.epoch,
                            data_reg.generation, data_reg.index};

endmodule

FILE: sv/ghalloc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ghalloc_ctrl
// Allocator controller: reads the slot and free-stack memories, decides the
// operation, writes the memories back and keeps the counters and the epoch.
// Clear walks every appended slot one per cycle; the last waits for room.
// ----------------------------------------------------------------------------
module ghalloc_ctrl #(
    parameter int CAPACITY = 256
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    // Operation input
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic [ghalloc_pkg::MODE_W-1:0]          in_mode,
    input  logic [ghalloc_pkg::HIDX_W-1:0]          in_index,
    input  logic [ghalloc_pkg::GEN_W-1:0]           in_generation,
    input  logic [ghalloc_pkg::EPOCH_W-1:0]         in_epoch,
    // Result to the output stage
    output logic                                    res_valid,
    input  logic                                    res_ready,
    output ghalloc_pkg::result_t                    res,
    // Slot memory: {alive, generation}
    output logic                                    slot_rd_en,
    output logic [$clog2(CAPACITY)-1:0]             slot_rd_addr,
    input  logic [ghalloc_pkg::GEN_W:0]             slot_rd_data,
    output logic                                    slot_wr_en,
    output logic [$clog2(CAPACITY)-1:0]             slot_wr_addr,
    output logic [ghalloc_pkg::GEN_W:0]             slot_wr_data,
    // Free-stack memory
    output logic                                    stack_rd_en,
    output logic [$clog2(CAPACITY)-1:0]             stack_rd_addr,
    input  logic [$clog2(CAPACITY)-1:0]             stack_rd_data,
    output logic                                    stack_wr_en,
    output logic [$clog2(CAPACITY)-1:0]             stack_wr_addr,
    output logic [$clog2(CAPACITY)-1:0]             stack_wr_data
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > ghalloc_pkg::HIDX_W) ? CNT_W : ghalloc_pkg::HIDX_W;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    ghalloc_pkg::state_t state_reg;
    ghalloc_pkg::state_t state_next;

    logic [ghalloc_pkg::MODE_W-1:0]  mode_reg;
    logic [ghalloc_pkg::MODE_W-1:0]  mode_next;
    logic [ghalloc_pkg::HIDX_W-1:0]  index_reg;
    logic [ghalloc_pkg::HIDX_W-1:0]  index_next;
    logic [ghalloc_pkg::GEN_W-1:0]   gen_reg;
    logic [ghalloc_pkg::GEN_W-1:0]   gen_next;
    logic [ghalloc_pkg::EPOCH_W-1:0] epoch_reg;
    logic [ghalloc_pkg::EPOCH_W-1:0] epoch_next;
    logic [CNT_W-1:0]                free_cnt_reg;
    logic [CNT_W-1:0]                free_cnt_next;
    logic [CNT_W-1:0]                hwm_reg;
    logic [CNT_W-1:0]                hwm_next;
    logic [CNT_W-1:0]                live_cnt_reg;
    logic [CNT_W-1:0]                live_cnt_next;
    logic [ghalloc_pkg::EPOCH_W-1:0] scene_epoch_reg;
    logic [ghalloc_pkg::EPOCH_W-1:0] scene_epoch_next;
    logic [IDX_W-1:0]                sweep_idx_reg;
    logic [IDX_W-1:0]                sweep_idx_next;

    // Width adaptation between the 8-bit handle index and the slot index.
    logic [IDX_W+ghalloc_pkg::HIDX_W-1:0] in_addr_ext;
    logic [IDX_W+ghalloc_pkg::HIDX_W-1:0] idx_addr_ext;
    logic [IDX_W-1:0]                     in_addr;
    logic [IDX_W-1:0]                     idx_addr;
    logic [CMP_W+ghalloc_pkg::HIDX_W-1:0] idx_cmp_ext;
    logic [CMP_W+CNT_W-1:0]               hwm_cmp_ext;
    logic                                 idx_in_range;
    logic [CNT_W-1:0]                     free_cnt_dec;
    logic [CNT_W+IDX_W-1:0]               sweep_ext;
    logic [CNT_W-1:0]                     sweep_cnt_inc;
    logic                                 sweep_last;
    logic [IDX_W+ghalloc_pkg::HIDX_W-1:0] pop_idx_ext;
    logic [IDX_W+ghalloc_pkg::HIDX_W-1:0] hwm_idx_ext;
    logic [CNT_W+ghalloc_pkg::LIVE_W-1:0] live_ext;

    logic                            slot_alive;
    logic [ghalloc_pkg::GEN_W-1:0]   slot_gen;
    logic [ghalloc_pkg::GEN_W-1:0]   slot_gen_inc;
    logic                            slot_gen_max;
    logic                            handle_live;
    logic [ghalloc_pkg::GEN_W-1:0]   sweep_gen;
    logic                            epoch_exhausted;

    assign in_addr_ext  = {{IDX_W{1'b0}}, in_index};
    assign in_addr      = in_addr_ext[IDX_W-1:0];
    assign idx_addr_ext = {{IDX_W{1'b0}}, index_reg};
    assign idx_addr     = idx_addr_ext[IDX_W-1:0];
    assign idx_cmp_ext  = {{CMP_W{1'b0}}, index_reg};
    assign hwm_cmp_ext  = {{CMP_W{1'b0}}, hwm_reg};
    assign idx_in_range = idx_cmp_ext[CMP_W-1:0] < hwm_cmp_ext[CMP_W-1:0];
    assign free_cnt_dec = free_cnt_reg - CNT_ONE;
    assign sweep_ext    = {{CNT_W{1'b0}}, sweep_idx_reg};
    assign sweep_cnt_inc = sweep_ext[CNT_W-1:0] + CNT_ONE;
    assign sweep_last   = sweep_cnt_inc >= hwm_reg;
    assign pop_idx_ext  = {{ghalloc_pkg::HIDX_W{1'b0}}, stack_rd_data};
    assign hwm_idx_ext  = {{ghalloc_pkg::HIDX_W{1'b0}}, hwm_reg[IDX_W-1:0]};

    assign slot_alive   = slot_rd_data[ghalloc_pkg::GEN_W];
    assign slot_gen     = slot_rd_data[ghalloc_pkg::GEN_W-1:0];
    assign slot_gen_inc = slot_gen + ghalloc_pkg::GEN_FIRST;
    assign slot_gen_max = slot_gen == ghalloc_pkg::GEN_MAX;
    assign handle_live  = (epoch_reg == scene_epoch_reg) && idx_in_range && slot_alive &&
                          (slot_gen == gen_reg);
    // A slot swept by clear: a live slot moves to its next generation unless at the last.
    assign sweep_gen    = (slot_alive && !slot_gen_max) ? slot_gen_inc : slot_gen;
    assign epoch_exhausted = scene_epoch_reg == ghalloc_pkg::EPOCH_MAX;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ghalloc_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ghalloc_pkg::ST_LOOKUP;
                end
            end
            ghalloc_pkg::ST_LOOKUP:
            begin
                if (res_ready)
                begin
                    if (mode_reg == ghalloc_pkg::MODE_ALLOC && free_cnt_reg != '0)
                    begin
                        state_next = ghalloc_pkg::ST_POP;
                    end
                    else if (mode_reg == ghalloc_pkg::MODE_CLEAR && !epoch_exhausted &&
                             hwm_reg != '0)
                    begin
                        state_next = ghalloc_pkg::ST_SWEEP;
                    end
                    else
                    begin
                        state_next = ghalloc_pkg::ST_IDLE;
                    end
                end
            end
            ghalloc_pkg::ST_POP:
            begin
                if (res_ready)
                begin
                    state_next = ghalloc_pkg::ST_IDLE;
                end
            end
            ghalloc_pkg::ST_SWEEP:
            begin
                if (sweep_last && res_ready)
                begin
                    state_next = ghalloc_pkg::ST_IDLE;
                end
            end
        endcase
    end

    // Datapath, memory accesses and result
    always_comb
    begin
        in_ready         = 1'b0;
        mode_next        = mode_reg;
        index_next       = index_reg;
        gen_next         = gen_reg;
        epoch_next       = epoch_reg;
        free_cnt_next    = free_cnt_reg;
        hwm_next         = hwm_reg;
        live_cnt_next    = live_cnt_reg;
        scene_epoch_next = scene_epoch_reg;
        sweep_idx_next   = sweep_idx_reg;

        slot_rd_en    = 1'b0;
        slot_rd_addr  = in_addr;
        slot_wr_en    = 1'b0;
        slot_wr_addr  = idx_addr;
        slot_wr_data  = {1'b0, slot_gen};
        stack_rd_en   = 1'b0;
        stack_rd_addr = free_cnt_dec[IDX_W-1:0];
        stack_wr_en   = 1'b0;
        stack_wr_addr = free_cnt_reg[IDX_W-1:0];
        stack_wr_data = idx_addr;

        res_valid      = 1'b0;
        res.status     = ghalloc_pkg::STATUS_OK;
        res.index      = '0;
        res.generation = '0;
        res.is_live    = 1'b0;

        unique case (state_reg)
            ghalloc_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    mode_next   = in_mode;
                    index_next  = in_index;
                    gen_next    = in_generation;
                    epoch_next  = in_epoch;
                    slot_rd_en  = 1'b1;
                    stack_rd_en = 1'b1;
                end
            end
            ghalloc_pkg::ST_LOOKUP:
            begin
                if (res_ready)
                begin
                    case (mode_reg)
                        ghalloc_pkg::MODE_ALLOC:
                        begin
                            if (free_cnt_reg != '0)
                            begin
                                // Fetch the generation of the slot on top of the stack.
                                slot_rd_en   = 1'b1;
                                slot_rd_addr = stack_rd_data;
                            end
                            else if (hwm_reg < CAP_CNT)
                            begin
                                slot_wr_en     = 1'b1;
                                slot_wr_addr   = hwm_reg[IDX_W-1:0];
                                slot_wr_data   = {1'b1, ghalloc_pkg::GEN_FIRST};
                                hwm_next       = hwm_reg + CNT_ONE;
                                live_cnt_next  = live_cnt_reg + CNT_ONE;
                                res_valid      = 1'b1;
                                res.index      = hwm_idx_ext[ghalloc_pkg::HIDX_W-1:0];
                                res.generation = ghalloc_pkg::GEN_FIRST;
                            end
                            else
                            begin
                                res_valid  = 1'b1;
                                res.status = ghalloc_pkg::STATUS_FULL;
                            end
                        end
                        ghalloc_pkg::MODE_RELEASE:
                        begin
                            res_valid = 1'b1;
                            if (handle_live)
                            begin
                                slot_wr_en    = 1'b1;
                                slot_wr_data  = {1'b0, slot_gen_max ? slot_gen : slot_gen_inc};
                                live_cnt_next = live_cnt_reg - CNT_ONE;
                                // A slot at its last generation is retired for good.
                                if (!slot_gen_max && free_cnt_reg < CAP_CNT)
                                begin
                                    stack_wr_en   = 1'b1;
                                    free_cnt_next = free_cnt_reg + CNT_ONE;
                                end
                            end
                            else
                            begin
                                res.status = ghalloc_pkg::STATUS_STALE;
                            end
                        end
                        ghalloc_pkg::MODE_CHECK:
                        begin
                            res_valid   = 1'b1;
                            res.is_live = handle_live;
                        end
                        ghalloc_pkg::MODE_CLEAR:
                        begin
                            if (epoch_exhausted)
                            begin
                                res_valid  = 1'b1;
                                res.status = ghalloc_pkg::STATUS_EXHAUSTED;
                            end
                            else if (hwm_reg == '0)
                            begin
                                free_cnt_next    = '0;
                                live_cnt_next    = '0;
                                scene_epoch_next = scene_epoch_reg + 1'b1;
                                res_valid        = 1'b1;
                            end
                            else
                            begin
                                free_cnt_next  = '0;
                                slot_rd_en     = 1'b1;
                                slot_rd_addr   = '0;
                                sweep_idx_next = '0;
                            end
                        end
                        ghalloc_pkg::MODE_QUERY:
                        begin
                            res_valid = 1'b1;
                            if (idx_in_range && slot_alive)
                            begin
                                res.index      = index_reg;
                                res.generation = slot_gen;
                            end
                            else
                            begin
                                res.status = ghalloc_pkg::STATUS_NOT_LIVE;
                            end
                        end
                        default:
                        begin
                            res_valid = 1'b1;
                        end
                    endcase
                end
            end
            ghalloc_pkg::ST_POP:
            begin
                if (res_ready)
                begin
                    slot_wr_en     = 1'b1;
                    slot_wr_addr   = stack_rd_data;
                    slot_wr_data   = {1'b1, slot_gen};
                    free_cnt_next  = free_cnt_dec;
                    live_cnt_next  = live_cnt_reg + CNT_ONE;
                    res_valid      = 1'b1;
                    res.index      = pop_idx_ext[ghalloc_pkg::HIDX_W-1:0];
                    res.generation = slot_gen;
                end
            end
            ghalloc_pkg::ST_SWEEP:
            begin
                // Reads run one slot ahead of the write-back; the last slot
                // waits for room in the output stage before it is written.
                if (!sweep_last || res_ready)
                begin
                    slot_wr_en    = 1'b1;
                    slot_wr_addr  = sweep_idx_reg;
                    slot_wr_data  = {1'b0, sweep_gen};
                    stack_wr_data = sweep_idx_reg;
                    if (sweep_gen != ghalloc_pkg::GEN_MAX)
                    begin
                        stack_wr_en   = 1'b1;
                        free_cnt_next = free_cnt_reg + CNT_ONE;
                    end
                    if (!sweep_last)
                    begin
                        slot_rd_en     = 1'b1;
                        slot_rd_addr   = sweep_cnt_inc[IDX_W-1:0];
                        sweep_idx_next = sweep_cnt_inc[IDX_W-1:0];
                    end
                    else
                    begin
                        live_cnt_next    = '0;
                        scene_epoch_next = scene_epoch_reg + 1'b1;
                        res_valid        = 1'b1;
                    end
                end
            end
        endcase

        live_ext       = {{ghalloc_pkg::LIVE_W{1'b0}}, live_cnt_next};
        res.epoch      = scene_epoch_next;
        res.live_total = live_ext[ghalloc_pkg::LIVE_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ghalloc_pkg::ST_IDLE;
            free_cnt_reg    <= '0;
            hwm_reg         <= '0;
            live_cnt_reg    <= '0;
            scene_epoch_reg <= ghalloc_pkg::EPOCH_W'(1);
        end
        else
        begin
            state_reg       <= state_next;
            free_cnt_reg    <= free_cnt_next;
            hwm_reg         <= hwm_next;
            live_cnt_reg    <= live_cnt_next;
            scene_epoch_reg <= scene_epoch_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg      <= mode_next;
        index_reg     <= index_next;
        gen_reg       <= gen_next;
        epoch_reg     <= epoch_next;
        sweep_idx_reg <= sweep_idx_next;
    end

endmodule

FILE: sv/generational_handle_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// generational_handle_allocator
// Generational slot map that hands out, retires, checks and looks up handles.
// ----------------------------------------------------------------------------
// Usage: one operation enters per transfer on the s_axis stream and exactly
// one result leaves per operation on the m_axis stream, in order. The input
// tuser carries the operation (allocate, release, check, clear, query) and
// tdata the handle: slot index, generation and scene epoch. The result tuser
// carries the status, tdata the handle handed out or found, the epoch and
// the live count after the operation, and the answer of a check.
// The block works on one operation at a time. Check, query, release and
// allocate at the high-water mark are accepted, then looked up and written
// back; allocate from the free stack has an extra pop step, because the
// popped slot needs a second read of the slot memory. Clear, unless the
// epoch is exhausted, walks every slot below the high-water mark through
// the slot memory port, one slot a cycle; the last slot waits for room in
// the output register. Each result passes through that register to m_axis.
// After reset no slot is allocated, the live count is zero and the epoch is
// one; the memories need no clearing pass since only appended slots and
// occupied stack entries are ever used. When the receiver stalls, the result
// waits in the output register and the block holds the next result until
// that register frees up; s_axis_tready falls while an operation is pending.
// ----------------------------------------------------------------------------
module generational_handle_allocator #(
    parameter int CAPACITY = 256
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // handle_index[7:0], handle_generation[39:8], handle_epoch[71:40]
    input  logic [ghalloc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // mode[2:0]
    input  logic [ghalloc_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // out_index[7:0], out_generation[39:8], out_epoch[71:40], is_live[72],
    // live_total[81:73], zero fill[87:82]
    output logic [ghalloc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // status[2:0]
    output logic [ghalloc_pkg::OUT_TUSER_W-1:0] m_axis_tuser
);

    localparam int IDX_W = $clog2(CAPACITY);

    // Result handoff between the controller and the output register.
    logic                 res_valid;
    logic                 res_ready;
    ghalloc_pkg::result_t res;

    // Slot memory holds {alive, generation} for every slot.
    logic                          slot_rd_en;
    logic [IDX_W-1:0]              slot_rd_addr;
    logic [ghalloc_pkg::GEN_W:0]   slot_rd_data;
    logic                          slot_wr_en;
    logic [IDX_W-1:0]              slot_wr_addr;
    logic [ghalloc_pkg::GEN_W:0]   slot_wr_data;

    // Free stack holds the indexes of released and swept slots; the top is the
    // entry just below the free count.
    logic                          stack_rd_en;
    logic [IDX_W-1:0]              stack_rd_addr;
    logic [IDX_W-1:0]              stack_rd_data;
    logic                          stack_wr_en;
    logic [IDX_W-1:0]              stack_wr_addr;
    logic [IDX_W-1:0]              stack_wr_data;

    ghalloc_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_axis_tvalid),
        .in_ready      (s_axis_tready),
        .in_mode       (s_axis_tuser[2:0]),
        .in_index      (s_axis_tdata[7:0]),
        .in_generation (s_axis_tdata[39:8]),
        .in_epoch      (s_axis_tdata[71:40]),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .res           (res),
        .slot_rd_en    (slot_rd_en),
        .slot_rd_addr  (slot_rd_addr),
        .slot_rd_data  (slot_rd_data),
        .slot_wr_en    (slot_wr_en),
        .slot_wr_addr  (slot_wr_addr),
        .slot_wr_data  (slot_wr_data),
        .stack_rd_en   (stack_rd_en),
        .stack_rd_addr (stack_rd_addr),
        .stack_rd_data (stack_rd_data),
        .stack_wr_en   (stack_wr_en),
        .stack_wr_addr (stack_wr_addr),
        .stack_wr_data (stack_wr_data)
    );

    ghalloc_ram #(
        .WIDTH (ghalloc_pkg::GEN_W + 1),
        .DEPTH (CAPACITY)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (slot_wr_en),
        .wr_addr (slot_wr_addr),
        .wr_data (slot_wr_data),
        .rd_en   (slot_rd_en),
        .rd_addr (slot_rd_addr),
        .rd_data (slot_rd_data)
    );

    ghalloc_ram #(
        .WIDTH (IDX_W),
        .DEPTH (CAPACITY)
    ) u_stack_ram (
        .clk     (clk),
        .wr_en   (stack_wr_en),
        .wr_addr (stack_wr_addr),
        .wr_data (stack_wr_data),
        .rd_en   (stack_rd_en),
        .rd_addr (stack_rd_addr),
        .rd_data (stack_rd_data)
    );

    ghalloc_outreg u_outreg (
        .clk           (clk),
        .rst_n         (rst_n),
        .res_valid     (res_valid),
        .res           (res),
        .res_ready     (res_ready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

`ifndef SYNTHESIS
    // The controller never hands over a result the output register cannot hold.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_ready)
        else $error("result issued while the output register is full");

    // Operations are taken one at a time: an accepted transfer closes the input.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second operation accepted while one is pending");

    // A result handed to the output register shows on the stream next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |=> m_axis_tvalid)
        else $error("result lost between controller and output register");
`endif

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the generational handle allocator.
// ----------------------------------------------------------------------------
// Operations go in over s_axis and results are checked as they come out of
// m_axis. A predictor inside the bench keeps its own slot table, free stack
// and epoch. It works out the answer for every accepted operation and queues
// it. The run has three parts. A short directed part touches each operation
// and the corner answers. A fill part drives the table to full and sweeps it
// with a clear. A random part mostly uses handles that are really live,
// mixed with damaged handles and junk operations. Both streams stall at
// random, except in stretches that run at full rate.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int SLOTS       = 256;
    localparam int STALL_PCT   = 29;
    localparam int IDLE_LIMIT  = 5000;
    localparam int RANDOM_OPS  = 600;
    localparam int MAX_REPORTS = 10;
    localparam int TAIL_CYCLES = 20;
    localparam logic [ghalloc_pkg::MODE_W-1:0] MODE_TOP = '1;

    logic                                clk           = 1'b0;
    logic                                rst_n         = 1'b0;
    logic                                s_axis_tvalid = 1'b0;
    logic                                s_axis_tready;
    logic [ghalloc_pkg::IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic [ghalloc_pkg::IN_TUSER_W-1:0]  s_axis_tuser  = '0;
    logic                                m_axis_tvalid;
    logic                                m_axis_tready = 1'b0;
    logic [ghalloc_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic [ghalloc_pkg::OUT_TUSER_W-1:0] m_axis_tuser;

    // Predicted allocator state. The generation store only gets read below
    // the high-water mark, so its zero start value never matters.
    bit [ghalloc_pkg::GEN_W-1:0]     slot_gen   [SLOTS];
    bit                              slot_live  [SLOTS];
    bit [ghalloc_pkg::HIDX_W-1:0]    free_slots [SLOTS];
    int                              free_top   = 0;
    int                              high_mark  = 0;
    int                              live_num   = 0;
    logic [ghalloc_pkg::EPOCH_W-1:0] cur_epoch  = ghalloc_pkg::EPOCH_W'(1);

    ghalloc_pkg::result_t             pending_results[$];
    bit                               throttle    = 1'b1;
    int                               mismatches  = 0;
    int                               unexpected  = 0;
    int                               idle_cycles = 0;
    int                               mode_seen   [8];
    int                               status_seen [8];
    logic [ghalloc_pkg::STATUS_W-1:0] last_status = ghalloc_pkg::STATUS_OK;

    generational_handle_allocator #(
        .CAPACITY(SLOTS)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic bit holds_live(input logic [ghalloc_pkg::HIDX_W-1:0] idx,
                                      input logic [ghalloc_pkg::GEN_W-1:0] gen,
                                      input logic [ghalloc_pkg::EPOCH_W-1:0] ep);
        return ep == cur_epoch && int'(idx) < high_mark && slot_live[idx]
               && slot_gen[idx] == gen;
    endfunction

    function automatic ghalloc_pkg::result_t apply_op(
        input logic [ghalloc_pkg::MODE_W-1:0]  op,
        input logic [ghalloc_pkg::HIDX_W-1:0]  idx,
        input logic [ghalloc_pkg::GEN_W-1:0]   gen,
        input logic [ghalloc_pkg::EPOCH_W-1:0] ep);
        ghalloc_pkg::result_t r;
        int                   s;
        r = '0;
        case (op)
            ghalloc_pkg::MODE_ALLOC:
            begin
                if (free_top > 0)
                begin
                    free_top--;
                    s = free_slots[free_top];
                    slot_live[s] = 1'b1;
                    live_num++;
                    r.index      = ghalloc_pkg::HIDX_W'(s);
                    r.generation = slot_gen[s];
                end
                else if (high_mark < SLOTS)
                begin
                    s = high_mark;
                    slot_gen[s]  = ghalloc_pkg::GEN_FIRST;
                    slot_live[s] = 1'b1;
                    high_mark++;
                    live_num++;
                    r.index      = ghalloc_pkg::HIDX_W'(s);
                    r.generation = ghalloc_pkg::GEN_FIRST;
                end
                else
                begin
                    r.status = ghalloc_pkg::STATUS_FULL;
                end
            end
            ghalloc_pkg::MODE_RELEASE:
            begin
                if (holds_live(idx, gen, ep))
                begin
                    slot_live[idx] = 1'b0;
                    live_num--;
                    // A slot at the top generation is retired for good.
                    if (slot_gen[idx] != ghalloc_pkg::GEN_MAX)
                    begin
                        slot_gen[idx]++;
                        if (free_top < SLOTS)
                        begin
                            free_slots[free_top] = idx;
                            free_top++;
                        end
                    end
                end
                else
                begin
                    r.status = ghalloc_pkg::STATUS_STALE;
                end
            end
            ghalloc_pkg::MODE_CHECK:
            begin
                r.is_live = holds_live(idx, gen, ep);
            end
            ghalloc_pkg::MODE_CLEAR:
            begin
                if (cur_epoch == ghalloc_pkg::EPOCH_MAX)
                begin
                    r.status = ghalloc_pkg::STATUS_EXHAUSTED;
                end
                else
                begin
                    // The free stack is rebuilt in ascending slot order.
                    free_top = 0;
                    for (int i = 0; i < high_mark; i++)
                    begin
                        if (slot_live[i])
                        begin
                            slot_live[i] = 1'b0;
                            if (slot_gen[i] != ghalloc_pkg::GEN_MAX)
                                slot_gen[i]++;
                        end
                        if (slot_gen[i] != ghalloc_pkg::GEN_MAX)
                        begin
                            free_slots[free_top] = ghalloc_pkg::HIDX_W'(i);
                            free_top++;
                        end
                    end
                    live_num = 0;
                    cur_epoch++;
                end
            end
            ghalloc_pkg::MODE_QUERY:
            begin
                if (int'(idx) < high_mark && slot_live[idx])
                begin
                    r.index      = idx;
                    r.generation = slot_gen[idx];
                end
                else
                begin
                    r.status = ghalloc_pkg::STATUS_NOT_LIVE;
                end
            end
            default:
            begin
            end
        endcase
        r.epoch      = cur_epoch;
        r.live_total = ghalloc_pkg::LIVE_W'(live_num);
        return r;
    endfunction

    // Returns a slot that is live right now, or -1 when none is.
    function automatic int pick_live();
        int start;
        int i;
        if (live_num == 0)
            return -1;
        start = $urandom_range(SLOTS - 1);
        for (int k = 0; k < SLOTS; k++)
        begin
            i = (start + k) % SLOTS;
            if (slot_live[i])
                return i;
        end
        return -1;
    endfunction

    // ------------------------------------------------------------------------
    // Operation sender and stream helpers
    // ------------------------------------------------------------------------
    // The task returns just after the accepting edge and leaves tvalid high.
    // The next call or drain_results lowers it or replaces the operation at
    // the following falling edge, before the block can sample it again.
    task automatic send_op(input logic [ghalloc_pkg::MODE_W-1:0]  op,
                           input logic [ghalloc_pkg::HIDX_W-1:0]  idx,
                           input logic [ghalloc_pkg::GEN_W-1:0]   gen,
                           input logic [ghalloc_pkg::EPOCH_W-1:0] ep);
        ghalloc_pkg::result_t r;
        @(negedge clk);
        while (throttle && $urandom_range(99) < STALL_PCT)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {ep, gen, idx};
        do @(posedge clk); while (!s_axis_tready);
        r = apply_op(op, idx, gen, ep);
        pending_results.insert(pending_results.size(), r);
        mode_seen[op]++;
        status_seen[r.status]++;
        last_status = r.status;
    endtask

    // Operation that ignores the handle fields, so they carry noise.
    task automatic send_bare(input logic [ghalloc_pkg::MODE_W-1:0] op);
        send_op(op, ghalloc_pkg::HIDX_W'($urandom), $urandom, $urandom);
    endtask

    // Operation on the exact handle held in a live slot.
    task automatic send_handle(input logic [ghalloc_pkg::MODE_W-1:0] op, input int s);
        send_op(op, ghalloc_pkg::HIDX_W'(s), slot_gen[s], cur_epoch);
    endtask

    // Operation on a handle that is close to a live one but damaged: one bit
    // of the generation or the epoch flipped, the previous epoch, or another
    // index.
    task automatic send_broken(input logic [ghalloc_pkg::MODE_W-1:0] op);
        int                              s;
        logic [ghalloc_pkg::HIDX_W-1:0]  idx;
        logic [ghalloc_pkg::GEN_W-1:0]   gen;
        logic [ghalloc_pkg::EPOCH_W-1:0] ep;
        s = pick_live();
        if (s < 0)
        begin
            idx = ghalloc_pkg::HIDX_W'($urandom);
            gen = $urandom;
            ep  = cur_epoch;
        end
        else
        begin
            idx = ghalloc_pkg::HIDX_W'(s);
            gen = slot_gen[s];
            ep  = cur_epoch;
            case ($urandom_range(3))
                0: gen[$urandom_range(ghalloc_pkg::GEN_W - 1)] ^= 1'b1;
                1: ep[$urandom_range(ghalloc_pkg::EPOCH_W - 1)] ^= 1'b1;
                2: ep = cur_epoch - 1;
                default: idx[$urandom_range(ghalloc_pkg::HIDX_W - 1)] ^= 1'b1;
            endcase
        end
        send_op(op, idx, gen, ep);
    endtask

    // Holds the sender back until every queued result has come out.
    task automatic drain_results();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_directed();
        throttle = 1'b1;
        // Empty table: nothing is live and nothing has been appended yet.
        send_op(ghalloc_pkg::MODE_CHECK, '0, '0, '0);
        send_op(ghalloc_pkg::MODE_QUERY, '1, '1, '1);
        send_op(ghalloc_pkg::MODE_RELEASE, '0, ghalloc_pkg::GEN_FIRST, cur_epoch);
        // Three appends at the high-water mark.
        repeat (3) send_bare(ghalloc_pkg::MODE_ALLOC);
        send_handle(ghalloc_pkg::MODE_CHECK, 0);
        send_op(ghalloc_pkg::MODE_CHECK, '0, ghalloc_pkg::GEN_FIRST + 1, cur_epoch);
        send_op(ghalloc_pkg::MODE_CHECK, '0, ghalloc_pkg::GEN_FIRST, cur_epoch + 1);
        // Release, then the same handle again, which must now be stale.
        send_handle(ghalloc_pkg::MODE_RELEASE, 1);
        send_op(ghalloc_pkg::MODE_RELEASE, ghalloc_pkg::HIDX_W'(1),
                ghalloc_pkg::GEN_FIRST, cur_epoch);
        send_op(ghalloc_pkg::MODE_QUERY, ghalloc_pkg::HIDX_W'(1), '0, '0);
        // Reuse from the free stack with the bumped generation.
        send_bare(ghalloc_pkg::MODE_ALLOC);
        send_op(ghalloc_pkg::MODE_QUERY, ghalloc_pkg::HIDX_W'(1), '0, '0);
        send_op(ghalloc_pkg::MODE_RELEASE, ghalloc_pkg::HIDX_W'(2), '1, '1);
        for (int m = int'(ghalloc_pkg::MODE_QUERY) + 1; m <= int'(MODE_TOP); m++)
            send_bare(ghalloc_pkg::MODE_W'(m));
        // Clear: handles of the old epoch go stale, the stack is refilled.
        send_bare(ghalloc_pkg::MODE_CLEAR);
        send_op(ghalloc_pkg::MODE_CHECK, '0, ghalloc_pkg::GEN_FIRST, cur_epoch - 1);
        send_bare(ghalloc_pkg::MODE_ALLOC);
        send_handle(ghalloc_pkg::MODE_RELEASE, 2);
        send_op(ghalloc_pkg::MODE_QUERY, '0, '0, '0);
        send_bare(ghalloc_pkg::MODE_ALLOC);
    endtask

    // Runs the table to full at full rate, then sweeps every slot.
    task automatic test_fill();
        int fulls;
        throttle = 1'b0;
        fulls    = 0;
        while (fulls < 2)
        begin
            send_bare(ghalloc_pkg::MODE_ALLOC);
            if (last_status == ghalloc_pkg::STATUS_FULL)
                fulls++;
        end
        send_op(ghalloc_pkg::MODE_QUERY, '1, '0, '0);
        send_handle(ghalloc_pkg::MODE_RELEASE, SLOTS - 1);
        send_bare(ghalloc_pkg::MODE_ALLOC);
        send_handle(ghalloc_pkg::MODE_CHECK, SLOTS - 1);
        send_bare(ghalloc_pkg::MODE_CLEAR);
        send_bare(ghalloc_pkg::MODE_ALLOC);
        send_op(ghalloc_pkg::MODE_QUERY, '1, '0, '0);
        throttle = 1'b1;
        drain_results();
    endtask

    // Mostly well-formed traffic on live handles. The allocate share follows
    // the live count.
    task automatic test_random(input int count);
        int                             alloc_pct;
        int                             pick;
        int                             s;
        logic [ghalloc_pkg::MODE_W-1:0] op;
        for (int k = 0; k < count; k++)
        begin
            if (k % 200 == 100)
                drain_results();
            if (k % 150 == 40)
                throttle = 1'b0;
            else if (k % 150 == 80)
                throttle = 1'b1;
            alloc_pct = (live_num > 200) ? 15 : ((live_num < 20) ? 45 : 30);
            pick = $urandom_range(alloc_pct + 64);
            s    = pick_live();
            if (pick < alloc_pct)
            begin
                send_bare(ghalloc_pkg::MODE_ALLOC);
            end
            else if (pick < alloc_pct + 25)
            begin
                if (s >= 0)
                    send_handle(ghalloc_pkg::MODE_RELEASE, s);
                else
                    send_broken(ghalloc_pkg::MODE_RELEASE);
            end
            else if (pick < alloc_pct + 35)
            begin
                if (s >= 0)
                    send_handle(ghalloc_pkg::MODE_CHECK, s);
                else
                    send_broken(ghalloc_pkg::MODE_CHECK);
            end
            else if (pick < alloc_pct + 41)
            begin
                send_broken(ghalloc_pkg::MODE_CHECK);
            end
            else if (pick < alloc_pct + 47)
            begin
                send_broken(ghalloc_pkg::MODE_RELEASE);
            end
            else if (pick < alloc_pct + 57)
            begin
                if (high_mark > 0 && $urandom_range(3) != 0)
                    send_op(ghalloc_pkg::MODE_QUERY,
                            ghalloc_pkg::HIDX_W'($urandom_range(high_mark - 1)),
                            $urandom, $urandom);
                else
                    send_bare(ghalloc_pkg::MODE_QUERY);
            end
            else if (pick < alloc_pct + 59)
            begin
                send_bare(ghalloc_pkg::MODE_CLEAR);
            end
            else
            begin
                // Junk: any mode, unused ones included, with random fields.
                if ($urandom_range(2) == 0)
                    op = ghalloc_pkg::MODE_W'($urandom_range(
                             int'(ghalloc_pkg::MODE_QUERY) + 1, int'(MODE_TOP)));
                else
                    op = ghalloc_pkg::MODE_W'($urandom_range(int'(MODE_TOP)));
                send_bare(op);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side: random stalls, comparison against the oldest prediction
    // ------------------------------------------------------------------------
    always @(negedge clk)
        m_axis_tready <= !throttle || ($urandom_range(99) >= STALL_PCT);

    always @(posedge clk)
    begin : result_check
        ghalloc_pkg::result_t want;
        ghalloc_pkg::result_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.status     = m_axis_tuser;
            got.index      = m_axis_tdata[7:0];
            got.generation = m_axis_tdata[39:8];
            got.epoch      = m_axis_tdata[71:40];
            got.is_live    = m_axis_tdata[72];
            got.live_total = m_axis_tdata[81:73];
            if (pending_results.size() == 0)
            begin
                unexpected++;
                if (mismatches + unexpected <= MAX_REPORTS)
                    $display("Unexpected result at %0t: status %0d index %0d gen %h",
                             $realtime, got.status, got.index, got.generation);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.status != want.status || got.index != want.index
                    || got.generation != want.generation || got.epoch != want.epoch
                    || got.is_live != want.is_live || got.live_total != want.live_total)
                begin
                    mismatches++;
                    if (mismatches + unexpected <= MAX_REPORTS)
                    begin
                        $display("Mismatch at %0t", $realtime);
                        $display({"  expected: status %0d index %0d gen %h epoch %h",
                                  " live %0d total %0d"},
                                 want.status, want.index, want.generation, want.epoch,
                                 want.is_live, want.live_total);
                        $display({"  actual:   status %0d index %0d gen %h epoch %h",
                                  " live %0d total %0d"},
                                 got.status, got.index, got.generation, got.epoch,
                                 got.is_live, got.live_total);
                    end
                end
            end
        end
    end

    // Ends a hung run: counts cycles with no transfer on either stream.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Watchdog: no transfer for %0d cycles", IDLE_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_fill();
        test_random(RANDOM_OPS);
        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display({"Covered %0d allocate, %0d release, %0d check, %0d clear,",
                  " %0d query, %0d unused"},
                 mode_seen[ghalloc_pkg::MODE_ALLOC], mode_seen[ghalloc_pkg::MODE_RELEASE],
                 mode_seen[ghalloc_pkg::MODE_CHECK], mode_seen[ghalloc_pkg::MODE_CLEAR],
                 mode_seen[ghalloc_pkg::MODE_QUERY],
                 mode_seen[5] + mode_seen[6] + mode_seen[7]);
        $display("Answers: %0d ok, %0d full, %0d stale, %0d not live; final epoch %0d",
                 status_seen[ghalloc_pkg::STATUS_OK], status_seen[ghalloc_pkg::STATUS_FULL],
                 status_seen[ghalloc_pkg::STATUS_STALE],
                 status_seen[ghalloc_pkg::STATUS_NOT_LIVE], cur_epoch);
        if (mismatches == 0 && unexpected == 0 && pending_results.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
